// File: rtl/fbt_pkg.sv
// ============================================================================
// fbt_pkg
// Shared types and constants for the flash breakpoint table: item layouts,
// command and mark codes, configuration register indexes and reset values.
// ============================================================================
package fbt_pkg;

    localparam int ADDR_W = 20;
    localparam int DATA_W = 16;
    localparam int CNT_W  = 9;
    localparam int CFG_INDEX_W = 2;

    localparam int SEGMENT_BYTES_DEF = 512;
    localparam int SEGMENT_COUNT_DEF = 128;

    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [ADDR_W-1:0] FLASH_START_RST = 20'd0;
    localparam logic [ADDR_W-1:0] FLASH_END_RST   = 20'd65535;
    localparam logic [DATA_W-1:0] BREAK_WORD_RST  = 16'd17283;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FLASH_START     = 2'd0,
        CFG_FLASH_END       = 2'd1,
        CFG_BREAK_WORD      = 2'd2,
        CFG_INSTANT_CLEANUP = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_QUERY   = 3'd2,
        CMD_COMMIT  = 3'd3,
        CMD_CLOSE   = 3'd4,
        CMD_HIDE    = 3'd5,
        CMD_RESTORE = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        MK_NONE     = 2'd0,
        MK_PENDING  = 2'd1,
        MK_ACTIVE   = 2'd2,
        MK_INACTIVE = 2'd3
    } t_mark;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic              in_range;
        logic [1:0]        mark;
        logic [DATA_W-1:0] original;
        logic [DATA_W-1:0] write_data;
        logic              erase_needed;
        logic              segment_selected;
    } t_out_item;

endpackage

// File: rtl/fbt_addr_map.sv
// ============================================================================
// fbt_addr_map
// Three-stage map from a window offset to its segment number and its word
// index in the table. The segment is found by a reciprocal multiply with one
// correction step; the word index follows without a further multiply.
// ============================================================================
module fbt_addr_map
    import fbt_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int SW = 7,
    parameter int AW = 15
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_off,
    output logic [SW-1:0]     o_seg,
    output logic [AW-1:0]     o_idx
);

    localparam int SBW = $clog2(SEGMENT_BYTES + 1);
    localparam int PW  = ADDR_W + SBW;
    localparam logic [ADDR_W-1:0] RECIP = ADDR_W'((2 ** ADDR_W) / SEGMENT_BYTES);
    localparam logic [ADDR_W-1:0] SB_L  = ADDR_W'(SEGMENT_BYTES);
    localparam bit SEG_ODD = (SEGMENT_BYTES % 2) != 0;

    logic [2*ADDR_W-1:0] w_prod;
    logic [PW-1:0]       w_qd;
    logic [ADDR_W-1:0]   w_rem;
    logic [ADDR_W:0]     w_sum;

    logic [ADDR_W-1:0] r_q_est;
    logic [ADDR_W-1:0] r_seg;
    logic [SW-1:0]     r_seg_out;
    logic [AW-1:0]     r_idx;

    // The estimate is never above the true quotient and at most one below it.
    assign w_prod = {{ADDR_W{1'b0}}, i_off} * {{ADDR_W{1'b0}}, RECIP};
    assign w_qd   = {{SBW{1'b0}}, r_q_est} * PW'(SEGMENT_BYTES);
    assign w_rem  = i_off - w_qd[ADDR_W-1:0];

    // With odd segments each segment holds one word more than its byte span
    // covers, so the word index is (offset + segment) / 2.
    assign w_sum = {1'b0, i_off} + (SEG_ODD ? {1'b0, r_seg} : {(ADDR_W + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        r_q_est   <= w_prod[2*ADDR_W-1:ADDR_W];
        r_seg     <= (w_rem >= SB_L) ? r_q_est + 1'b1 : r_q_est;
        r_seg_out <= SW'(r_seg);
        r_idx     <= AW'(w_sum[ADDR_W:1]);
    end

    assign o_seg = r_seg_out;
    assign o_idx = r_idx;

endmodule

// File: rtl/flash_breakpoint_table_top.sv
// ============================================================================
// flash_breakpoint_table_top
// Breakpoint table for a flash window: per-word marks and saved words in one
// memory, per-segment pending and inactive counts in a second memory.
// ============================================================================
// Usage:
// Input items (cmd, addr, data) arrive on i_in_valid / o_in_stall / i_in_item
// and are taken when valid is high and stall is low. Each item gives exactly
// one result item on o_out_valid / i_out_stall / o_out_item.
// Configuration registers are written on i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data. The user must write them only while no item
// is in flight; the block itself does not enforce this. An accepted item
// passes through S_Q, S_REM and S_IDX for the segment and word index
// computation (the window check rides along in S_Q), then S_RD for the
// memory read and S_EXEC to modify; the update is written back in the
// cycle the result is loaded into the output register. One item is worked
// on at a time and the block returns to S_IDLE before it takes the next.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls, the following item finishes its work and then waits
// with its write-back until the output register is free.
// After reset the block sweeps both memories, one entry per cycle, over
// SEGMENT_COUNT * ((SEGMENT_BYTES + 1) / 2) words (32768 by default) and
// holds o_in_stall high during the sweep; configuration writes are taken.
// ============================================================================
module flash_breakpoint_table_top
    import fbt_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data
);

    localparam int WORDS_PER_SEG = (SEGMENT_BYTES + 1) / 2;
    localparam int TABLE_WORDS   = SEGMENT_COUNT * WORDS_PER_SEG;
    localparam int AW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam int SW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam logic [23:0] TABLE_BYTES = 24'(SEGMENT_COUNT * SEGMENT_BYTES);
    localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_WORDS - 1);
    localparam logic [AW:0]   SEG_LIMIT = (AW + 1)'(SEGMENT_COUNT);

    typedef struct packed {
        logic [1:0]        mark;
        logic [DATA_W-1:0] saved;
    } t_word_ent;

    typedef struct packed {
        logic [CNT_W-1:0] pend;
        logic [CNT_W-1:0] inact;
    } t_cnt_ent;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_Q,
        S_REM,
        S_IDX,
        S_RD,
        S_EXEC
    } t_state;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : c;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    // Configuration registers.
    logic [ADDR_W-1:0] r_flash_start;
    logic [ADDR_W-1:0] r_flash_end;
    logic [DATA_W-1:0] r_break_word;
    logic              r_instant_cleanup;

    // Control and item registers.
    t_state            r_state;
    logic [AW-1:0]     r_clr_ptr;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_in_item          r_in;
    logic [ADDR_W-1:0] r_off;
    logic              r_win_ok;
    logic              r_in_range;

    // Memories and their registered read data.
    t_word_ent mem_word [TABLE_WORDS];
    t_cnt_ent  mem_cnt  [SEGMENT_COUNT];
    t_word_ent r_word_rd;
    t_cnt_ent  r_cnt_rd;

    logic [SW-1:0]     w_seg;
    logic [AW-1:0]     w_idx;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_out_free;
    logic              w_exec_go;
    logic              w_clr_cnt;

    t_word_ent n_word;
    t_cnt_ent  n_cnt;
    t_out_item n_out;
    logic      w_sel_pre;
    logic      w_saved_pre;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_waddr    = {i_in_item.addr[ADDR_W-1:1], 1'b0};
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_exec_go  = (r_state == S_EXEC) && w_out_free;
    assign w_clr_cnt  = ({1'b0, r_clr_ptr} < SEG_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_start     <= FLASH_START_RST;
            r_flash_end       <= FLASH_END_RST;
            r_break_word      <= BREAK_WORD_RST;
            r_instant_cleanup <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLASH_START:     r_flash_start     <= i_cfg_data;
                CFG_FLASH_END:       r_flash_end       <= i_cfg_data;
                CFG_BREAK_WORD:      r_break_word      <= i_cfg_data[DATA_W-1:0];
                CFG_INSTANT_CLEANUP: r_instant_cleanup <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fbt_addr_map #(
        .SEGMENT_BYTES(SEGMENT_BYTES),
        .SW(SW),
        .AW(AW)
    ) u_addr_map (
        .i_clk(i_clk),
        .i_off(r_off),
        .o_seg(w_seg),
        .o_idx(w_idx)
    );

    // Word memory: cleared by the sweep, read in S_RD, written on commit of
    // the result.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_word[r_clr_ptr] <= '0;
        end else if (w_exec_go && r_in_range) begin
            mem_word[w_idx] <= n_word;
        end
        if (r_state == S_RD) begin
            r_word_rd <= mem_word[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            if (w_clr_cnt) begin
                mem_cnt[r_clr_ptr[SW-1:0]] <= '0;
            end
        end else if (w_exec_go && r_in_range) begin
            mem_cnt[w_seg] <= n_cnt;
        end
        if (r_state == S_RD) begin
            r_cnt_rd <= mem_cnt[w_seg];
        end
    end

    always_comb begin
        n_word      = r_word_rd;
        n_cnt       = r_cnt_rd;
        n_out       = '0;
        w_saved_pre = (r_word_rd.mark == MK_ACTIVE) || (r_word_rd.mark == MK_INACTIVE);
        w_sel_pre   = (r_cnt_rd.pend != '0) || (r_instant_cleanup && (r_cnt_rd.inact != '0));

        if (r_in.cmd == CMD_COMMIT) begin
            n_out.write_data = r_in.data;
        end else if ((r_in.cmd == CMD_HIDE) || (r_in.cmd == CMD_RESTORE)) begin
            n_out.write_data = {8'h00, r_in.data[7:0]};
        end

        case (r_in.cmd)
            CMD_SET: begin
                if (r_word_rd.mark == MK_NONE) begin
                    n_word.mark = MK_PENDING;
                    n_cnt.pend  = cnt_inc(r_cnt_rd.pend);
                    n_out.ok    = 1'b1;
                end else if (r_word_rd.mark == MK_INACTIVE) begin
                    n_word.mark = MK_ACTIVE;
                    n_cnt.inact = cnt_dec(r_cnt_rd.inact);
                    n_out.ok    = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (r_word_rd.mark == MK_PENDING) begin
                    n_word.mark = MK_NONE;
                    n_cnt.pend  = cnt_dec(r_cnt_rd.pend);
                    n_out.ok    = 1'b1;
                end else if (r_word_rd.mark == MK_ACTIVE) begin
                    n_word.mark = MK_INACTIVE;
                    n_cnt.inact = cnt_inc(r_cnt_rd.inact);
                    n_out.ok    = 1'b1;
                end
            end
            CMD_QUERY: begin
                n_out.ok = w_saved_pre;
            end
            CMD_COMMIT: begin
                if (w_sel_pre) begin
                    if (r_word_rd.mark == MK_INACTIVE) begin
                        n_word.mark        = MK_NONE;
                        n_out.write_data   = r_word_rd.saved;
                        n_out.erase_needed = 1'b1;
                    end else if (r_word_rd.mark == MK_PENDING) begin
                        n_word.mark        = MK_ACTIVE;
                        n_word.saved       = r_in.data;
                        n_out.write_data   = r_break_word;
                        n_out.erase_needed = ((r_in.data & r_break_word) != r_break_word);
                    end
                end
            end
            CMD_CLOSE: begin
                n_cnt = '0;
            end
            CMD_HIDE: begin
                if (w_saved_pre) begin
                    n_out.write_data = r_in.addr[0] ? {8'h00, r_word_rd.saved[15:8]}
                                                    : {8'h00, r_word_rd.saved[7:0]};
                end
            end
            CMD_RESTORE: begin
                if (w_saved_pre) begin
                    if (r_in.addr[0]) begin
                        n_word.saved = {r_in.data[7:0], r_word_rd.saved[7:0]};
                    end else begin
                        n_word.saved = {r_word_rd.saved[15:8], r_in.data[7:0]};
                    end
                end
            end
            default: ;
        endcase

        if (r_in_range) begin
            n_out.in_range = 1'b1;
            n_out.mark     = n_word.mark;
            if ((n_word.mark == MK_ACTIVE) || (n_word.mark == MK_INACTIVE)) begin
                n_out.original = n_word.saved;
            end
            n_out.segment_selected = (n_cnt.pend != '0)
                                  || (r_instant_cleanup && (n_cnt.inact != '0));
        end else begin
            // Outside the window only the pass-through write data survives.
            n_out.ok           = 1'b0;
            n_out.erase_needed = 1'b0;
            if (r_in.cmd == CMD_COMMIT) begin
                n_out.write_data = r_in.data;
            end else if (r_in.cmd == CMD_HIDE) begin
                n_out.write_data = {8'h00, r_in.data[7:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + 1'b1;
                    if (r_clr_ptr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in     <= i_in_item;
                        r_off    <= w_waddr - r_flash_start;
                        r_win_ok <= (w_waddr >= r_flash_start) && (w_waddr <= r_flash_end);
                        r_state  <= S_Q;
                    end
                end
                S_Q: begin
                    r_in_range <= r_win_ok && ({4'h0, r_off} < TABLE_BYTES);
                    r_state    <= S_REM;
                end
                S_REM: begin
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_out_item <= n_out;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: bench/flash_breakpoint_table_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// flash_breakpoint_table_top_tb
// Self-checking bench for the flash breakpoint table. A queue of commands
// feeds a clocked driver. Every accepted item runs through a local model of
// the mark, saved-word and segment-count tables. A clocked monitor compares
// each result item with the oldest prediction. The window, break word and
// cleanup mode change between phases. Both handshakes idle at random. A
// short single-word cycle runs one segment's counts up and closes it.
// ============================================================================
module flash_breakpoint_table_top_tb;
    import fbt_pkg::*;

    localparam int WORDS_PER_SEG = (SEGMENT_BYTES_DEF + 1) / 2;
    localparam int TABLE_WORDS   = SEGMENT_COUNT_DEF * WORDS_PER_SEG;
    localparam int STALL_LIMIT   = 150000;
    localparam int LONG_HOLD     = 80;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    // Local copy of the block's tables and registers.
    t_mark             word_marks [TABLE_WORDS];
    logic [DATA_W-1:0] saved_words [TABLE_WORDS];
    logic [CNT_W-1:0]  pend_cnt [SEGMENT_COUNT_DEF];
    logic [CNT_W-1:0]  inact_cnt [SEGMENT_COUNT_DEF];
    logic [ADDR_W-1:0] cfg_start;
    logic [ADDR_W-1:0] cfg_end;
    logic [DATA_W-1:0] cfg_brk;
    logic              cfg_cleanup;

    t_in_item  cmd_backlog [$];
    t_out_item due_results [$];
    int items_offered = 0;
    int items_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int gap_pct = 0;
    int hold_pct = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int idle_cycles = 0;

    flash_breakpoint_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    function automatic logic seg_busy(input int seg);
        return pend_cnt[seg] != '0 || (cfg_cleanup && inact_cnt[seg] != '0);
    endfunction

    // Applies one item to the local tables and returns the result it gives.
    function automatic t_out_item table_update(input t_in_item it);
        t_out_item         r;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] off;
        int                seg;
        int                idx;
        logic              hit;
        logic              saved;
        t_mark             m;
        r = '0;
        hit = 1'b0;
        seg = 0;
        idx = 0;
        waddr = it.addr & ~ADDR_W'(1);
        if (waddr >= cfg_start && waddr <= cfg_end) begin
            off = waddr - cfg_start;
            seg = int'(off / SEGMENT_BYTES_DEF);
            if (seg < SEGMENT_COUNT_DEF) begin
                idx = seg * WORDS_PER_SEG + int'(off % SEGMENT_BYTES_DEF) / 2;
                hit = 1'b1;
            end
        end
        if (it.cmd == CMD_COMMIT) begin
            r.write_data = it.data;
        end else if (it.cmd == CMD_HIDE || it.cmd == CMD_RESTORE) begin
            r.write_data = {8'd0, it.data[7:0]};
        end
        if (hit) begin
            m = word_marks[idx];
            saved = (m == MK_ACTIVE || m == MK_INACTIVE);
            case (it.cmd)
                CMD_SET: begin
                    if (m == MK_NONE) begin
                        word_marks[idx] = MK_PENDING;
                        pend_cnt[seg] = cnt_up(pend_cnt[seg]);
                        r.ok = 1'b1;
                    end else if (m == MK_INACTIVE) begin
                        word_marks[idx] = MK_ACTIVE;
                        inact_cnt[seg] = cnt_down(inact_cnt[seg]);
                        r.ok = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (m == MK_PENDING) begin
                        word_marks[idx] = MK_NONE;
                        pend_cnt[seg] = cnt_down(pend_cnt[seg]);
                        r.ok = 1'b1;
                    end else if (m == MK_ACTIVE) begin
                        word_marks[idx] = MK_INACTIVE;
                        inact_cnt[seg] = cnt_up(inact_cnt[seg]);
                        r.ok = 1'b1;
                    end
                end
                CMD_QUERY: r.ok = saved;
                CMD_COMMIT: begin
                    if (seg_busy(seg)) begin
                        if (m == MK_INACTIVE) begin
                            word_marks[idx] = MK_NONE;
                            r.write_data = saved_words[idx];
                            r.erase_needed = 1'b1;
                        end else if (m == MK_PENDING) begin
                            word_marks[idx] = MK_ACTIVE;
                            saved_words[idx] = it.data;
                            r.erase_needed = (it.data & cfg_brk) != cfg_brk;
                            r.write_data = cfg_brk;
                        end
                    end
                end
                CMD_CLOSE: begin
                    pend_cnt[seg] = '0;
                    inact_cnt[seg] = '0;
                end
                CMD_HIDE: begin
                    if (saved) begin
                        r.write_data = {8'd0, it.addr[0] ? saved_words[idx][15:8]
                                                         : saved_words[idx][7:0]};
                    end
                end
                CMD_RESTORE: begin
                    if (saved) begin
                        if (it.addr[0]) saved_words[idx][15:8] = it.data[7:0];
                        else saved_words[idx][7:0] = it.data[7:0];
                    end
                end
                default: ;
            endcase
            r.mark = word_marks[idx];
            if (r.mark == MK_ACTIVE || r.mark == MK_INACTIVE) r.original = saved_words[idx];
            r.segment_selected = seg_busy(seg);
        end
        r.in_range = hit;
        return r;
    endfunction

    task automatic offer(input logic [2:0] c, input logic [ADDR_W-1:0] a,
                         input logic [DATA_W-1:0] d);
        cmd_backlog.push_back(t_in_item'{cmd: c, addr: a, data: d});
        items_offered++;
    endtask

    // A word mostly in segment 0, 1 or the last, else in any segment, near either end of the segment.
    function automatic logic [ADDR_W-1:0] hot_addr();
        int seg;
        int word;
        case ($urandom_range(0, 3))
            0: seg = 0;
            1: seg = 1;
            2: seg = SEGMENT_COUNT_DEF - 1;
            default: seg = $urandom_range(0, SEGMENT_COUNT_DEF - 1);
        endcase
        if ($urandom_range(0, 1)) word = $urandom_range(0, 3);
        else word = WORDS_PER_SEG - 1 - $urandom_range(0, 3);
        return ADDR_W'(cfg_start + seg * SEGMENT_BYTES_DEF + word * 2);
    endfunction

    // Set, commit, poke at the snapshot, remove and commit back, at times closing the segment.
    task automatic push_lifecycle();
        logic [ADDR_W-1:0] a;
        logic [2:0]        c;
        a = hot_addr();
        offer(CMD_SET, a, DATA_W'($urandom()));
        offer(CMD_COMMIT, a, DATA_W'($urandom()));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0: c = CMD_HIDE;
                1: c = CMD_RESTORE;
                default: c = CMD_QUERY;
            endcase
            offer(c, a | ADDR_W'($urandom_range(0, 1)), DATA_W'($urandom()));
        end
        offer(CMD_REMOVE, a, DATA_W'($urandom()));
        // A pending neighbor, when it falls in the same segment, keeps the segment selected for the restoring commit.
        if ($urandom_range(0, 1)) offer(CMD_SET, ADDR_W'(a + 2), DATA_W'($urandom()));
        offer(CMD_COMMIT, a, DATA_W'($urandom()));
        if ($urandom_range(0, 3) == 0) offer(CMD_CLOSE, a, DATA_W'($urandom()));
    endtask

    task automatic push_single();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 3))
            0, 1: a = ADDR_W'($urandom());
            2: a = hot_addr() | ADDR_W'($urandom_range(0, 1));
            default: begin
                case ($urandom_range(0, 3))
                    0: a = ADDR_W'(cfg_start - 1);
                    1: a = cfg_start;
                    2: a = cfg_end;
                    default: a = ADDR_W'(cfg_end + 1);
                endcase
            end
        endcase
        offer(3'($urandom_range(0, 7)), a, DATA_W'($urandom()));
    endtask

    task automatic cycle_word(input logic [ADDR_W-1:0] a, input int n);
        repeat (n) begin
            offer(CMD_SET, a, DATA_W'($urandom()));
            offer(CMD_COMMIT, a, DATA_W'($urandom()));
            offer(CMD_REMOVE, a, DATA_W'($urandom()));
            offer(CMD_COMMIT, a, DATA_W'($urandom()));
        end
    endtask

    task automatic wait_idle();
        while (items_taken != items_offered || due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [ADDR_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FLASH_START:     cfg_start = val;
            CFG_FLASH_END:       cfg_end = val;
            CFG_BREAK_WORD:      cfg_brk = val[DATA_W-1:0];
            CFG_INSTANT_CLEANUP: cfg_cleanup = val[0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] start_a, input logic [ADDR_W-1:0] end_a,
                             input logic [DATA_W-1:0] brk, input logic cleanup,
                             input int n, input int gap, input int hold);
        int first;
        write_reg(CFG_FLASH_START, start_a);
        write_reg(CFG_FLASH_END, end_a);
        write_reg(CFG_BREAK_WORD, ADDR_W'(brk));
        write_reg(CFG_INSTANT_CLEANUP, ADDR_W'(cleanup));
        gap_pct = gap;
        hold_pct = hold;
        first = items_offered;
        while (items_offered - first < n) begin
            if ($urandom_range(0, 9) < 7) push_lifecycle();
            else push_single();
        end
        wait_idle();
    endtask

    // Driver: predicts each item as it is taken, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                due_results.push_back(table_update(in_item));
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    in_valid <= 1'b1;
                    in_item <= cmd_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Monitor: checks results and decides the receiver's stall.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result item with no prediction waiting");
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    cmp_field("ok", want.ok, out_item.ok);
                    cmp_field("in_range", want.in_range, out_item.in_range);
                    cmp_field("mark", want.mark, out_item.mark);
                    cmp_field("original", want.original, out_item.original);
                    cmp_field("write_data", want.write_data, out_item.write_data);
                    cmp_field("erase_needed", want.erase_needed, out_item.erase_needed);
                    cmp_field("segment_selected", want.segment_selected,
                              out_item.segment_selected);
                end
            end
            // One long hold lets the block fill up and push back on the sender.
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!long_hold_done && results_seen >= 100) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < hold_pct);
            end
        end
    end

    // The reset sweep is the longest correct stretch without a handshake.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0] sat_addr;
        for (int k = 0; k < TABLE_WORDS; k++) begin
            word_marks[k] = MK_NONE;
            saved_words[k] = '0;
        end
        for (int k = 0; k < SEGMENT_COUNT_DEF; k++) begin
            pend_cnt[k] = '0;
            inact_cnt[k] = '0;
        end
        cfg_start = FLASH_START_RST;
        cfg_end = FLASH_END_RST;
        cfg_brk = BREAK_WORD_RST;
        cfg_cleanup = 1'b0;
        gap_pct = 25;
        hold_pct = 57;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the mark states under the reset window.
        offer(CMD_QUERY,   20'h00000, 16'h0000);
        offer(CMD_SET,     20'h00000, 16'h0000);
        offer(CMD_SET,     20'h00000, 16'h0000);  // already pending
        offer(CMD_COMMIT,  20'h00000, 16'hFFFF);  // covers the break word, no erase
        offer(CMD_SET,     20'h00002, 16'h0000);
        offer(CMD_COMMIT,  20'h00002, 16'h0000);  // needs an erase
        offer(CMD_HIDE,    20'h00001, 16'h0012);
        offer(CMD_RESTORE, 20'h00000, 16'hFFA5);
        offer(CMD_HIDE,    20'h00000, 16'h0000);
        offer(CMD_REMOVE,  20'h00000, 16'h0000);
        offer(CMD_REMOVE,  20'h00000, 16'h0000);  // already inactive
        offer(CMD_SET,     20'h00000, 16'h0000);  // inactive back to active
        offer(CMD_REMOVE,  20'h00000, 16'h0000);
        offer(CMD_COMMIT,  20'h00000, 16'hAAAA);  // restores the saved word
        offer(CMD_REMOVE,  20'h00004, 16'h0000);
        offer(CMD_HIDE,    20'h00005, 16'h00C3);  // nothing saved, byte passes through
        offer(CMD_CLOSE,   20'h00000, 16'h0000);
        offer(CMD_REMOVE,  20'h00002, 16'h0000);
        offer(CMD_COMMIT,  20'h00002, 16'h5555);  // segment not selected
        offer(CMD_SET,     20'h00004, 16'h0000);
        offer(CMD_CLOSE,   20'h00004, 16'h0000);
        offer(CMD_REMOVE,  20'h00004, 16'h0000);  // pending count held at zero
        offer(CMD_SET,     20'h0FFFF, 16'hFFFF);  // last word of the window
        offer(CMD_COMMIT,  20'h10000, 16'hBEEF);  // just past the window
        offer(CMD_UNUSED,  20'h00002, 16'hFFFF);
        wait_idle();

        run_phase(20'h10000, 20'h1FFFF, DATA_W'($urandom()), 1'b1, 300, 25, 57);
        run_phase(20'h00000, 20'hFFFFF, 16'hFFFF, 1'b0, 300, 57, 25);
        run_phase(20'hF0001, 20'hFFFFF, 16'h0000, 1'b1, 250, 57, 25);
        run_phase(20'h08000, 20'h07FFF, DATA_W'($urandom()), 1'b0, 30, 0, 0);
        run_phase(20'h00100, 20'h0FFFE, DATA_W'($urandom()), 1'($urandom_range(0, 1)),
                  300, 0, 0);

        // Restore the reset window with instant cleanup on, then cycle one word so the pending count
        // of its segment climbs, close the segment and cycle it again.
        run_phase(20'h00000, 20'h0FFFF, BREAK_WORD_RST, 1'b1, 0, 0, 0);
        sat_addr = ADDR_W'(5 * SEGMENT_BYTES_DEF);
        cycle_word(sat_addr, 2);
        wait_idle();
        write_reg(CFG_INSTANT_CLEANUP, ADDR_W'(0));
        offer(CMD_CLOSE, sat_addr, 16'h0000);
        cycle_word(sat_addr, 8);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/fbt_pkg.sv
rtl/fbt_addr_map.sv
rtl/flash_breakpoint_table_top.sv
bench/flash_breakpoint_table_top_tb.sv
